@@ design/iida_pkg.sv @@
// Shared types and constants for the indexed insert/delete array unit.
package iida_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned CmdW          = 1;
  localparam int unsigned PosW          = 8;
  localparam int unsigned ValW          = 32;
  localparam int unsigned StatW         = 2;
  localparam int unsigned FillW         = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADINDEX  = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming request word
    logic execute;  // apply the held request and load the result word
  } ctrl_t;

endpackage

@@ design/iida_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
interface iida_req_if;
  logic                         valid;
  logic                         ready;
  logic [iida_pkg::CmdW-1:0]    cmd;
  logic [iida_pkg::PosW-1:0]    position;
  logic signed [iida_pkg::ValW-1:0] new_value;

  modport source (output valid, output cmd, output position, output new_value, input ready);
  modport sink   (input valid, input cmd, input position, input new_value, output ready);
endinterface

interface iida_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [iida_pkg::StatW-1:0]       status;
  logic signed [iida_pkg::ValW-1:0] removed_value;
  logic [iida_pkg::FillW-1:0]       fill_count;

  modport source (output valid, output status, output removed_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input fill_count,
                  output ready);
endinterface

@@ design/iida_ctrl.sv @@
// Controller: sequences capture, execute and result handshake for one word at a time.
module iida_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output iida_pkg::ctrl_t ctrl_o
);
  import iida_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // A new word may enter while the previous result is being taken.
  assign req_ready_o = (state_q == S_IDLE) && (!out_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_valid_q;

  assign ctrl_o.capture = accept;
  assign ctrl_o.execute = (state_q == S_EXEC);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.execute |-> !out_valid_q)
    else $error("result register busy while executing");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ctrl_o.execute)
    else $error("accepted word not executed next cycle");
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.execute |=> rsp_valid_o)
    else $error("executed word produced no result");
  a_no_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.execute |-> !req_ready_o)
    else $error("ready raised while executing");
`endif

endmodule

@@ design/iida_datapath.sv @@
// Datapath: row of entry cells with parallel shift, fill count and result register.
module iida_datapath #(
  parameter int unsigned Depth = iida_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iida_pkg::ctrl_t                     ctrl_i,
  input  logic [iida_pkg::CmdW-1:0]           cmd_i,
  input  logic [iida_pkg::PosW-1:0]           position_i,
  input  logic signed [iida_pkg::ValW-1:0]    new_value_i,
  output logic [iida_pkg::StatW-1:0]          status_o,
  output logic signed [iida_pkg::ValW-1:0]    removed_value_o,
  output logic [iida_pkg::FillW-1:0]          fill_count_o
);
  import iida_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_e                  cmd_q;
  logic [PosW-1:0]       pos_q;
  logic signed [ValW-1:0] val_q;

  logic signed [ValW-1:0] cells_q [Depth];
  logic signed [ValW-1:0] cells_d [Depth];
  logic [CntW-1:0]       count_q, count_d;

  status_e               status_q, status_d;
  logic signed [ValW-1:0] removed_q, removed_d;

  logic [CmpW-1:0]       pos_x, cnt_x;
  logic                  is_full, is_empty, ok;
  logic [CntW+FillW-1:0] fill_x;

  assign pos_x    = CmpW'(pos_q);
  assign cnt_x    = CmpW'(count_q);
  assign is_full  = (count_q == DepthCnt);
  assign is_empty = (count_q == '0);

  always_comb begin
    status_d = STAT_OK;
    if (cmd_q == CMD_INSERT) begin
      if (is_full) begin
        status_d = STAT_OVERFLOW;
      end else if (pos_x > cnt_x) begin
        status_d = STAT_BADINDEX;
      end
    end else begin
      if (is_empty) begin
        status_d = STAT_UNDERFLOW;
      end else if (pos_x >= cnt_x) begin
        status_d = STAT_BADINDEX;
      end
    end
  end

  assign ok = (status_d == STAT_OK);

  // A successful delete has pos below the count, so the low bits address a written cell.
  assign removed_d = (ok && cmd_q == CMD_DELETE) ? cells_q[pos_q[IdxW-1:0]] : '0;

  always_comb begin
    count_d = count_q;
    if (ok) begin
      count_d = (cmd_q == CMD_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  // Each cell chooses between holding, its lower neighbor, its upper neighbor or the new word.
  always_comb begin
    for (int unsigned i = 0; i < Depth; i++) begin
      cells_d[i] = cells_q[i];
      if (cmd_q == CMD_INSERT) begin
        if (CmpW'(i) == pos_x) begin
          cells_d[i] = val_q;
        end else if (CmpW'(i) > pos_x && i > 0) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else begin
        if (CmpW'(i) >= pos_x && i + 1 < Depth) begin
          cells_d[i] = cells_q[(i + 1 < Depth) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= position_i;
      val_q <= new_value_i;
    end
    if (ctrl_i.execute) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      if (ok) begin
        for (int unsigned i = 0; i < Depth; i++) begin
          cells_q[i] <= cells_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.execute) begin
      count_q <= count_d;
    end
  end

  assign fill_x          = {{FillW{1'b0}}, count_q};
  assign fill_count_o    = fill_x[FillW-1:0];
  assign status_o        = status_q;
  assign removed_value_o = removed_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("fill count above depth");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.execute |=> $stable(count_q))
    else $error("fill count moved without a request");
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.execute && !ok) |=> (count_q == $past(count_q) && removed_q == '0))
    else $error("rejected request changed the list or returned a word");
`endif

endmodule

@@ design/indexed_insert_delete_array_unit.sv @@
// A request word is captured when it is accepted, applied to the cell row in the execute state,
// and its result word is then registered and held valid until it is taken.
// The controller holds one request at a time and takes no new word while it executes one; the
// single shift step of the cell row sets the pace (capture, then execute).
// A waiting result does not block the next request when it is taken in the same cycle.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result; cells keep
// their contents and are only read after being written.
module indexed_insert_delete_array_unit #(
  parameter int unsigned Depth = iida_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iida_req_if.sink   req_i,
  iida_rsp_if.source rsp_o
);
  import iida_pkg::*;

  ctrl_t ctrl;

  iida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  iida_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (req_i.cmd),
    .position_i      (req_i.position),
    .new_value_i     (req_i.new_value),
    .status_o        (rsp_o.status),
    .removed_value_o (rsp_o.removed_value),
    .fill_count_o    (rsp_o.fill_count)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the indexed insert/delete array unit.
module testbench;
  import iida_pkg::*;

  localparam int unsigned Depth      = DEPTH_DEFAULT;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    status_e                 status;
    logic signed [ValW-1:0]  removed_value;
    logic [FillW-1:0]        fill_count;
  } outcome_t;

  typedef struct {
    cmd_e                    cmd;
    logic [PosW-1:0]         position;
    logic signed [ValW-1:0]  new_value;
    bit                      known;
    outcome_t                outcome;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iida_req_if req_if ();
  iida_rsp_if rsp_if ();

  indexed_insert_delete_array_unit #(
    .Depth(Depth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the list, updated when a request word is accepted.
  logic signed [ValW-1:0] list_mem [Depth];
  int unsigned            list_count = 0;

  outcome_t    pending_outcomes[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          filling = 1'b1;

  // Typed outcome of the word now on the request channel, if it has one.
  bit          row_known = 1'b0;
  outcome_t    row_outcome;

  function automatic outcome_t apply_request(cmd_e cmd, logic [PosW-1:0] pos,
                                             logic signed [ValW-1:0] val);
    outcome_t r;
    r.status        = STAT_OK;
    r.removed_value = '0;
    if (cmd == CMD_INSERT) begin
      if (list_count >= Depth) begin
        r.status = STAT_OVERFLOW;
      end else if (pos > list_count) begin
        r.status = STAT_BADINDEX;
      end else begin
        for (int unsigned i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos] = val;
        list_count++;
      end
    end else begin
      if (list_count == 0) begin
        r.status = STAT_UNDERFLOW;
      end else if (pos >= list_count) begin
        r.status = STAT_BADINDEX;
      end else begin
        r.removed_value = list_mem[pos];
        for (int unsigned i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
        list_count--;
      end
    end
    r.fill_count = FillW'(list_count);
    return r;
  endfunction

  function automatic outcome_t mk_outcome(status_e st, logic signed [ValW-1:0] rem,
                                          logic [FillW-1:0] fill);
    outcome_t r;
    r.status        = st;
    r.removed_value = rem;
    r.fill_count    = fill;
    return r;
  endfunction

  function automatic void add_row(cmd_e cmd, logic [PosW-1:0] pos,
                                  logic signed [ValW-1:0] val, bit known, outcome_t oc);
    stim_row_t row;
    row.cmd       = cmd;
    row.position  = pos;
    row.new_value = val;
    row.known     = known;
    row.outcome   = oc;
    directed_rows.push_back(row);
  endfunction

  // Request and result monitor: predicts on request words, checks result words.
  always @(posedge clk_i) begin
    outcome_t predicted;
    outcome_t want;
    bit       moved;
    moved = 1'b0;
    if (req_if.valid && req_if.ready) begin
      predicted = apply_request(cmd_e'(req_if.cmd), req_if.position, req_if.new_value);
      pending_outcomes.push_back(row_known ? row_outcome : predicted);
      moved = 1'b1;
    end
    if (rsp_if.valid && rsp_if.ready) begin
      moved = 1'b1;
      if (pending_outcomes.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want.removed_value,
                 rsp_if.removed_value);
          mismatches++;
        end
        if (rsp_if.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, rsp_if.fill_count);
          mismatches++;
        end
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_word(cmd_e cmd, logic [PosW-1:0] pos, logic signed [ValW-1:0] val,
                           bit known, outcome_t oc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.cmd       = cmd;
    req_if.position  = pos;
    req_if.new_value = val;
    row_known        = known;
    row_outcome      = oc;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    cmd_e                   cmd;
    cmd_e                   preferred;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    int unsigned            pick;
    if (list_count == Depth) filling = 1'b0;
    else if (list_count == 0) filling = 1'b1;
    preferred = filling ? CMD_INSERT : CMD_DELETE;
    pick = $urandom_range(0, 99);
    if (pick < 5) cmd = cmd_e'($urandom_range(0, 1));
    else if (pick < 80) cmd = preferred;
    else cmd = (preferred == CMD_INSERT) ? CMD_DELETE : CMD_INSERT;
    // Mostly legal indexes, with some anywhere in the 8-bit range.
    if (pick < 5 || $urandom_range(0, 99) < 12) pos = PosW'($urandom_range(0, 255));
    else if (cmd == CMD_INSERT) pos = PosW'($urandom_range(0, list_count));
    else pos = (list_count == 0) ? '0 : PosW'($urandom_range(0, list_count - 1));
    case ($urandom_range(0, 9))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = -1;
      3:       val = 0;
      default: val = $urandom;
    endcase
    send_word(cmd, pos, val, 1'b0, '0);
  endtask

  task automatic drain_results();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_INSERT;
    req_if.position  = '0;
    req_if.new_value = '0;
    row_outcome      = '0;

    // Empty list: the empty check wins over a bad index, inserts past the end fail.
    add_row(CMD_DELETE, 8'd0,   0,            1, mk_outcome(STAT_UNDERFLOW, 0, 0));
    add_row(CMD_DELETE, 8'd255, 32'sh7fff_ffff, 1, mk_outcome(STAT_UNDERFLOW, 0, 0));
    add_row(CMD_INSERT, 8'd1,   5,            1, mk_outcome(STAT_BADINDEX, 0, 0));
    add_row(CMD_INSERT, 8'd255, -1,           1, mk_outcome(STAT_BADINDEX, 0, 0));
    add_row(CMD_INSERT, 8'd0,   32'sh8000_0000, 1, mk_outcome(STAT_OK, 0, 1));
    add_row(CMD_INSERT, 8'd1,   32'sh7fff_ffff, 1, mk_outcome(STAT_OK, 0, 2));
    add_row(CMD_INSERT, 8'd0,   -1,           1, mk_outcome(STAT_OK, 0, 3));
    add_row(CMD_DELETE, 8'd3,   0,            1, mk_outcome(STAT_BADINDEX, 0, 3));
    add_row(CMD_DELETE, 8'd2,   0,            1, mk_outcome(STAT_OK, 32'sh7fff_ffff, 2));
    add_row(CMD_DELETE, 8'd0,   0,            1, mk_outcome(STAT_OK, -1, 1));
    // Fill the list up to its last entry at assorted positions.
    for (int unsigned i = 0; i < Depth - 1; i++) begin
      add_row(CMD_INSERT, PosW'((i * 7) % (i + 2)), ValW'(i * 32'h1357_9bdf), 0, '0);
    end
    // Full list: the full check wins over a bad index.
    add_row(CMD_INSERT, 8'd255, 42,           1, mk_outcome(STAT_OVERFLOW, 0, 16));
    add_row(CMD_DELETE, 8'd16,  0,            1, mk_outcome(STAT_BADINDEX, 0, 16));
    add_row(CMD_DELETE, 8'd15,  0,            0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 82;
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].position, directed_rows[i].new_value,
                directed_rows[i].known, directed_rows[i].outcome);
    end
    repeat (120) send_random();
    req_if.valid = 1'b0;
    // Hold the sender off until every result word is back.
    drain_results();

    send_idle_pct = 82;
    recv_idle_pct = 37;
    repeat (140) send_random();
    req_if.valid = 1'b0;
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (140) send_random();
    req_if.valid = 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
